>>> hdl/assert_macros.svh
// Assertion macros used by the RTL file of the block-to-node-path core.
// The assertions are active in simulation only; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/fbnp_pkg.sv
// Package for the file block to node path core: tree geometry constants,
// region codes and the derived boundaries and node numbers. No dependencies.
package fbnp_pkg;

    localparam int unsigned ADDRS_IN_INODE  = 256;
    localparam int unsigned ADDRS_PER_NODE  = 512;
    localparam int unsigned PTRS_PER_NODE   = 512;
    localparam int unsigned FIRST_NODE_SLOT = 257;

    // Node sizes are powers of two, so the index split is a set of bit fields.
    localparam int AN_W  = $clog2(ADDRS_PER_NODE);
    localparam int PN_W  = $clog2(PTRS_PER_NODE);
    localparam int REL_W = AN_W + 2 * PN_W;

    localparam longint unsigned PER_IND  = longint'(ADDRS_PER_NODE) * PTRS_PER_NODE;
    localparam longint unsigned PER_DIND = PER_IND * PTRS_PER_NODE;

    // First block number of each region of the tree.
    localparam longint unsigned BEG_DIR0 = ADDRS_IN_INODE;
    localparam longint unsigned BEG_DIR1 = BEG_DIR0 + ADDRS_PER_NODE;
    localparam longint unsigned BEG_IND0 = BEG_DIR1 + ADDRS_PER_NODE;
    localparam longint unsigned BEG_IND1 = BEG_IND0 + PER_IND;
    localparam longint unsigned BEG_DIND = BEG_IND1 + PER_IND;
    localparam longint unsigned END_DIND = BEG_DIND + PER_DIND;

    localparam logic [32:0] LIM_DIR0 = 33'(BEG_DIR0);
    localparam logic [32:0] LIM_DIR1 = 33'(BEG_DIR1);
    localparam logic [32:0] LIM_IND0 = 33'(BEG_IND0);
    localparam logic [32:0] LIM_IND1 = 33'(BEG_IND1);
    localparam logic [32:0] LIM_DIND = 33'(BEG_DIND);
    localparam logic [32:0] LIM_END  = 33'(END_DIND);

    localparam logic [9:0] SLOT_DIR0 = 10'(FIRST_NODE_SLOT);
    localparam logic [9:0] SLOT_DIR1 = 10'(FIRST_NODE_SLOT + 1);
    localparam logic [9:0] SLOT_IND0 = 10'(FIRST_NODE_SLOT + 2);
    localparam logic [9:0] SLOT_IND1 = 10'(FIRST_NODE_SLOT + 3);
    localparam logic [9:0] SLOT_DIND = 10'(FIRST_NODE_SLOT + 4);

    localparam logic [10:0] N1_DIR0 = 11'(1);
    localparam logic [10:0] N1_DIR1 = 11'(2);
    localparam logic [10:0] N1_IND0 = 11'(3);
    localparam logic [10:0] N1_IND1 = 11'(4 + PTRS_PER_NODE);
    localparam logic [10:0] N1_DIND = 11'(5 + 2 * PTRS_PER_NODE);
    localparam logic [18:0] N2_IND0 = 19'(4);
    localparam logic [18:0] N2_IND1 = 19'(5 + PTRS_PER_NODE);
    localparam logic [18:0] N2_DIND = 19'(6 + 2 * PTRS_PER_NODE);
    localparam logic [18:0] N3_DIND = 19'(7 + 2 * PTRS_PER_NODE);
    localparam logic [18:0] STRIDE_DIND = 19'(PTRS_PER_NODE + 1);

    localparam logic [1:0] LVL_0 = 2'd0;
    localparam logic [1:0] LVL_1 = 2'd1;
    localparam logic [1:0] LVL_2 = 2'd2;
    localparam logic [1:0] LVL_3 = 2'd3;

    typedef enum logic [2:0] {
        RGN_INODE,
        RGN_DIR0,
        RGN_DIR1,
        RGN_IND0,
        RGN_IND1,
        RGN_DIND,
        RGN_OOR
    } t_region;

endpackage

>>> hdl/file_block_to_node_path_core.sv
// Top level of the file block to node path core: a three-stage pipeline that
// maps a logical block number to its path in the inode pointer tree.
// Depends on fbnp_pkg and assert_macros.svh.
//
// The core accepts one block number word per clock while o_stall is low and
// returns one path word per input, in order. A word passes the stage one and
// stage two registers and then the output register. Stage one
// classifies the number into its tree region and subtracts the region's base,
// stage two splits the remainder into slot indexes and forms the
// double-indirect row product, and stage three adds the node numbers into the
// output register. A stall from the consumer freezes all three stages together,
// so o_stall is high exactly while a finished word waits and i_stall is high.
`include "assert_macros.svh"

module file_block_to_node_path_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_block_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_tree_level,
    output logic        o_out_of_range,
    output logic [9:0]  o_offset_0,
    output logic [8:0]  o_offset_1,
    output logic [8:0]  o_offset_2,
    output logic [8:0]  o_offset_3,
    output logic [10:0] o_node_offset_1,
    output logic [18:0] o_node_offset_2,
    output logic [18:0] o_node_offset_3
);
    import fbnp_pkg::*;

    logic w_adv;

    // Stage 1: region and offset within region.
    logic             r_v1;
    t_region          r_rgn1, n_rgn1;
    logic [REL_W-1:0] r_rel1, n_rel1;

    // Stage 2: split offsets.
    logic        r_v2;
    t_region     r_rgn2;
    logic [9:0]  r_o0_2, n_o0_2;
    logic [8:0]  r_o1_2, n_o1_2;
    logic [8:0]  r_o2_2, n_o2_2;
    logic [8:0]  r_o3_2, n_o3_2;
    logic [18:0] r_base2, n_base2;

    // Stage 3: output register.
    logic        r_v3;
    logic [1:0]  r_lvl, n_lvl;
    logic        r_oor, n_oor;
    logic [9:0]  r_o0, n_o0;
    logic [8:0]  r_o1, n_o1;
    logic [8:0]  r_o2, n_o2;
    logic [8:0]  r_o3, n_o3;
    logic [10:0] r_n1, n_n1;
    logic [18:0] r_n2, n_n2;
    logic [18:0] r_n3, n_n3;

    logic [32:0] w_blk;
    logic [31:0] w_base;
    logic [31:0] w_diff;
    logic [AN_W-1:0] w_lo;
    logic [PN_W-1:0] w_mid;
    logic [PN_W-1:0] w_hi;

    assign w_adv   = !(r_v3 && i_stall);
    assign o_stall = r_v3 && i_stall;

    // Stage 1: compare against the region boundaries and remove the base.
    always_comb begin
        w_blk = {1'b0, i_block_index};
        if (w_blk < LIM_DIR0) begin
            n_rgn1 = RGN_INODE;
            w_base = 32'd0;
        end else if (w_blk < LIM_DIR1) begin
            n_rgn1 = RGN_DIR0;
            w_base = LIM_DIR0[31:0];
        end else if (w_blk < LIM_IND0) begin
            n_rgn1 = RGN_DIR1;
            w_base = LIM_DIR1[31:0];
        end else if (w_blk < LIM_IND1) begin
            n_rgn1 = RGN_IND0;
            w_base = LIM_IND0[31:0];
        end else if (w_blk < LIM_DIND) begin
            n_rgn1 = RGN_IND1;
            w_base = LIM_IND1[31:0];
        end else if (w_blk < LIM_END) begin
            n_rgn1 = RGN_DIND;
            w_base = LIM_DIND[31:0];
        end else begin
            n_rgn1 = RGN_OOR;
            w_base = 32'd0;
        end
        w_diff = i_block_index - w_base;
        n_rel1 = w_diff[REL_W-1:0];
    end

    // Stage 2: the remainder splits into address index and pointer indexes.
    always_comb begin
        w_lo  = r_rel1[AN_W-1:0];
        w_mid = r_rel1[AN_W+PN_W-1:AN_W];
        w_hi  = r_rel1[REL_W-1:AN_W+PN_W];
        n_o0_2  = 10'd0;
        n_o1_2  = 9'd0;
        n_o2_2  = 9'd0;
        n_o3_2  = 9'd0;
        n_base2 = 19'd0;
        case (r_rgn1)
            RGN_INODE: begin
                n_o0_2 = r_rel1[9:0];
            end
            RGN_DIR0: begin
                n_o0_2 = SLOT_DIR0;
                n_o1_2 = 9'(w_lo);
            end
            RGN_DIR1: begin
                n_o0_2 = SLOT_DIR1;
                n_o1_2 = 9'(w_lo);
            end
            RGN_IND0: begin
                n_o0_2 = SLOT_IND0;
                n_o1_2 = 9'(w_mid);
                n_o2_2 = 9'(w_lo);
            end
            RGN_IND1: begin
                n_o0_2 = SLOT_IND1;
                n_o1_2 = 9'(w_mid);
                n_o2_2 = 9'(w_lo);
            end
            RGN_DIND: begin
                n_o0_2  = SLOT_DIND;
                n_o1_2  = 9'(w_hi);
                n_o2_2  = 9'(w_mid);
                n_o3_2  = 9'(w_lo);
                // Each indirect node under the double-indirect one spans a row
                // of itself plus its direct nodes.
                n_base2 = 19'(w_hi) * STRIDE_DIND;
            end
            default: begin
                n_o0_2 = 10'd0;
            end
        endcase
    end

    // Stage 3: level and node numbers.
    always_comb begin
        n_lvl = LVL_0;
        n_oor = 1'b0;
        n_o0  = r_o0_2;
        n_o1  = r_o1_2;
        n_o2  = r_o2_2;
        n_o3  = r_o3_2;
        n_n1  = 11'd0;
        n_n2  = 19'd0;
        n_n3  = 19'd0;
        case (r_rgn2)
            RGN_INODE: begin
                n_lvl = LVL_0;
            end
            RGN_DIR0: begin
                n_lvl = LVL_1;
                n_n1  = N1_DIR0;
            end
            RGN_DIR1: begin
                n_lvl = LVL_1;
                n_n1  = N1_DIR1;
            end
            RGN_IND0: begin
                n_lvl = LVL_2;
                n_n1  = N1_IND0;
                n_n2  = N2_IND0 + 19'(r_o1_2);
            end
            RGN_IND1: begin
                n_lvl = LVL_2;
                n_n1  = N1_IND1;
                n_n2  = N2_IND1 + 19'(r_o1_2);
            end
            RGN_DIND: begin
                n_lvl = LVL_3;
                n_n1  = N1_DIND;
                n_n2  = N2_DIND + r_base2;
                n_n3  = N3_DIND + r_base2 + 19'(r_o2_2);
            end
            default: begin
                n_oor = 1'b1;
                n_o0  = 10'd0;
                n_o1  = 9'd0;
                n_o2  = 9'd0;
                n_o3  = 9'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rgn1  <= n_rgn1;
            r_rel1  <= n_rel1;
            r_rgn2  <= r_rgn1;
            r_o0_2  <= n_o0_2;
            r_o1_2  <= n_o1_2;
            r_o2_2  <= n_o2_2;
            r_o3_2  <= n_o3_2;
            r_base2 <= n_base2;
            r_lvl   <= n_lvl;
            r_oor   <= n_oor;
            r_o0    <= n_o0;
            r_o1    <= n_o1;
            r_o2    <= n_o2;
            r_o3    <= n_o3;
            r_n1    <= n_n1;
            r_n2    <= n_n2;
            r_n3    <= n_n3;
        end
    end

    assign o_valid         = r_v3;
    assign o_tree_level    = r_lvl;
    assign o_out_of_range  = r_oor;
    assign o_offset_0      = r_o0;
    assign o_offset_1      = r_o1;
    assign o_offset_2      = r_o2;
    assign o_offset_3      = r_o3;
    assign o_node_offset_1 = r_n1;
    assign o_node_offset_2 = r_n2;
    assign o_node_offset_3 = r_n3;

    `ASSERT_IMPL(a_oor_clear, i_clk, i_rst_n, r_v3 && r_oor,
        r_lvl == LVL_0 && r_o0 == 10'd0 && r_n1 == 11'd0 && r_n2 == 19'd0 && r_n3 == 19'd0,
        "out-of-range word carries nonzero fields")
    `ASSERT_IMPL(a_lvl0_unused, i_clk, i_rst_n, r_v3 && r_lvl == LVL_0,
        r_o1 == 9'd0 && r_n1 == 11'd0, "level 0 word has a node on its path")
    `ASSERT_IMPL(a_lvl1_unused, i_clk, i_rst_n, r_v3 && r_lvl == LVL_1,
        r_o2 == 9'd0 && r_n2 == 19'd0 && r_n3 == 19'd0, "level 1 word has deeper fields set")
    `ASSERT_IMPL(a_lvl3_chain, i_clk, i_rst_n, r_v3 && r_lvl == LVL_3,
        r_n3 == r_n2 + 19'd1 + 19'(r_o2), "level 3 node numbers do not chain")

endmodule

>>> tb/node_path_checker.sv
// Checker for the file block to node path core: watches both channels, works out
// the expected tree path of each accepted block number and compares the path words.
// Depends on fbnp_pkg for the tree geometry and level codes.
module node_path_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_block_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_tree_level,
    input  logic        i_out_of_range,
    input  logic [9:0]  i_offset_0,
    input  logic [8:0]  i_offset_1,
    input  logic [8:0]  i_offset_2,
    input  logic [8:0]  i_offset_3,
    input  logic [10:0] i_node_offset_1,
    input  logic [18:0] i_node_offset_2,
    input  logic [18:0] i_node_offset_3,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fbnp_pkg::*;

    typedef struct packed {
        logic [1:0]  tree_level;
        logic        out_of_range;
        logic [9:0]  offset_0;
        logic [8:0]  offset_1;
        logic [8:0]  offset_2;
        logic [8:0]  offset_3;
        logic [10:0] node_offset_1;
        logic [18:0] node_offset_2;
        logic [18:0] node_offset_3;
    } t_node_path;

    t_node_path expected_paths[$];
    int         mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_paths.size();

    // Walks the regions of the pointer tree in order, subtracting each size.
    function automatic t_node_path node_path_of(input logic [31:0] blk);
        longint unsigned b;
        longint unsigned per_ind;
        longint unsigned per_dind;
        longint unsigned row;
        longint unsigned mid;
        t_node_path      p;
        p        = '0;
        b        = blk;
        per_ind  = longint'(ADDRS_PER_NODE) * PTRS_PER_NODE;
        per_dind = per_ind * PTRS_PER_NODE;
        if (b < ADDRS_IN_INODE) begin
            p.tree_level = LVL_0;
            p.offset_0   = 10'(b);
            return p;
        end
        b -= ADDRS_IN_INODE;
        if (b < ADDRS_PER_NODE) begin
            p.tree_level    = LVL_1;
            p.offset_0      = 10'(FIRST_NODE_SLOT);
            p.offset_1      = 9'(b);
            p.node_offset_1 = 11'd1;
            return p;
        end
        b -= ADDRS_PER_NODE;
        if (b < ADDRS_PER_NODE) begin
            p.tree_level    = LVL_1;
            p.offset_0      = 10'(FIRST_NODE_SLOT + 1);
            p.offset_1      = 9'(b);
            p.node_offset_1 = 11'd2;
            return p;
        end
        b -= ADDRS_PER_NODE;
        if (b < per_ind) begin
            row             = b / ADDRS_PER_NODE;
            p.tree_level    = LVL_2;
            p.offset_0      = 10'(FIRST_NODE_SLOT + 2);
            p.offset_1      = 9'(row);
            p.offset_2      = 9'(b % ADDRS_PER_NODE);
            p.node_offset_1 = 11'd3;
            p.node_offset_2 = 19'(4 + row);
            return p;
        end
        b -= per_ind;
        if (b < per_ind) begin
            row             = b / ADDRS_PER_NODE;
            p.tree_level    = LVL_2;
            p.offset_0      = 10'(FIRST_NODE_SLOT + 3);
            p.offset_1      = 9'(row);
            p.offset_2      = 9'(b % ADDRS_PER_NODE);
            p.node_offset_1 = 11'(4 + PTRS_PER_NODE);
            p.node_offset_2 = 19'(5 + PTRS_PER_NODE + row);
            return p;
        end
        b -= per_ind;
        if (b < per_dind) begin
            row             = b / per_ind;
            mid             = (b / ADDRS_PER_NODE) % PTRS_PER_NODE;
            p.tree_level    = LVL_3;
            p.offset_0      = 10'(FIRST_NODE_SLOT + 4);
            p.offset_1      = 9'(row);
            p.offset_2      = 9'(mid);
            p.offset_3      = 9'(b % ADDRS_PER_NODE);
            p.node_offset_1 = 11'(5 + 2 * PTRS_PER_NODE);
            p.node_offset_2 = 19'(6 + 2 * PTRS_PER_NODE + row * (PTRS_PER_NODE + 1));
            p.node_offset_3 = 19'(7 + 2 * PTRS_PER_NODE + row * (PTRS_PER_NODE + 1) + mid);
            return p;
        end
        p.out_of_range = 1'b1;
        return p;
    endfunction

    task automatic report_field(input string field, input longint exp, input longint act);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp, act);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_node_path exp;
        t_node_path got;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                expected_paths.push_back(node_path_of(i_block_index));
            if (i_out_valid && !i_out_stall) begin
                got = {i_tree_level, i_out_of_range, i_offset_0, i_offset_1, i_offset_2,
                       i_offset_3, i_node_offset_1, i_node_offset_2, i_node_offset_3};
                if (expected_paths.size() == 0) begin
                    $display("%0t: path word with none expected: expected nothing, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    exp = expected_paths.pop_front();
                    if (got.tree_level !== exp.tree_level)
                        report_field("tree_level", exp.tree_level, got.tree_level);
                    if (got.out_of_range !== exp.out_of_range)
                        report_field("out_of_range", exp.out_of_range, got.out_of_range);
                    if (got.offset_0 !== exp.offset_0)
                        report_field("offset_0", exp.offset_0, got.offset_0);
                    if (got.offset_1 !== exp.offset_1)
                        report_field("offset_1", exp.offset_1, got.offset_1);
                    if (got.offset_2 !== exp.offset_2)
                        report_field("offset_2", exp.offset_2, got.offset_2);
                    if (got.offset_3 !== exp.offset_3)
                        report_field("offset_3", exp.offset_3, got.offset_3);
                    if (got.node_offset_1 !== exp.node_offset_1)
                        report_field("node_offset_1", exp.node_offset_1, got.node_offset_1);
                    if (got.node_offset_2 !== exp.node_offset_2)
                        report_field("node_offset_2", exp.node_offset_2, got.node_offset_2);
                    if (got.node_offset_3 !== exp.node_offset_3)
                        report_field("node_offset_3", exp.node_offset_3, got.node_offset_3);
                end
            end
        end
    end

endmodule

>>> tb/file_block_to_node_path_core_test.sv
// Top of the file block to node path core testbench: drives block number words with
// random gaps and consumer stalls, and gives the verdict from the checker's counts.
// Depends on fbnp_pkg, node_path_checker and file_block_to_node_path_core.
module file_block_to_node_path_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import fbnp_pkg::*;

    localparam int RANDOM_WORDS = 550;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [31:0] i_block_index = '0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_tree_level;
    logic        o_out_of_range;
    logic [9:0]  o_offset_0;
    logic [8:0]  o_offset_1;
    logic [8:0]  o_offset_2;
    logic [8:0]  o_offset_3;
    logic [10:0] o_node_offset_1;
    logic [18:0] o_node_offset_2;
    logic [18:0] o_node_offset_3;
    int          fail_count;
    int          pending;
    int          sent = 0;

    always #2 i_clk = ~i_clk;

    file_block_to_node_path_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_block_index   (i_block_index),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_tree_level    (o_tree_level),
        .o_out_of_range  (o_out_of_range),
        .o_offset_0      (o_offset_0),
        .o_offset_1      (o_offset_1),
        .o_offset_2      (o_offset_2),
        .o_offset_3      (o_offset_3),
        .o_node_offset_1 (o_node_offset_1),
        .o_node_offset_2 (o_node_offset_2),
        .o_node_offset_3 (o_node_offset_3)
    );

    node_path_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_block_index   (i_block_index),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_tree_level    (o_tree_level),
        .i_out_of_range  (o_out_of_range),
        .i_offset_0      (o_offset_0),
        .i_offset_1      (o_offset_1),
        .i_offset_2      (o_offset_2),
        .i_offset_3      (o_offset_3),
        .i_node_offset_1 (o_node_offset_1),
        .i_node_offset_2 (o_node_offset_2),
        .i_node_offset_3 (o_node_offset_3),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Every fourth stretch of forty words runs back to back.
    function automatic int gap_for(input int k);
        if ((k / 40) % 4 == 3)
            return 0;
        return $urandom_range(14, 0);
    endfunction

    // Picks a region of the tree first so that the deep levels are well covered.
    function automatic logic [31:0] random_block_index();
        longint unsigned limits[6];
        longint unsigned b;
        limits = '{BEG_DIR0, BEG_DIR1, BEG_IND0, BEG_IND1, BEG_DIND, END_DIND};
        case ($urandom_range(11, 0))
            0:       b = $urandom_range(ADDRS_IN_INODE - 1, 0);
            1:       b = BEG_DIR0 + $urandom_range(ADDRS_PER_NODE - 1, 0);
            2:       b = BEG_DIR1 + $urandom_range(ADDRS_PER_NODE - 1, 0);
            3, 4:    b = BEG_IND0 + $urandom_range(32'(PER_IND - 1), 0);
            5, 6:    b = BEG_IND1 + $urandom_range(32'(PER_IND - 1), 0);
            7, 8:    b = BEG_DIND + $urandom_range(32'(PER_DIND - 1), 0);
            9:       b = $urandom_range(32'hFFFF_FFFF, 32'(END_DIND));
            10:      b = limits[$urandom_range(5, 0)] - $urandom_range(1, 0);
            default: b = $urandom();
        endcase
        return 32'(b);
    endfunction

    task automatic send_word(input logic [31:0] blk);
        int gap;
        gap = gap_for(sent);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_block_index <= blk;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    // Consumer: holds off path words for random gaps, which gap_for may make zero.
    initial begin
        int gap;
        int taken;
        taken = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = gap_for(taken);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            taken++;
        end
    end

    initial begin
        logic [31:0] directed[$];
        directed = '{32'd0, 32'(BEG_DIR0 - 1), 32'(BEG_DIR0), 32'(BEG_DIR1 - 1),
                     32'(BEG_DIR1), 32'(BEG_IND0 - 1), 32'(BEG_IND0),
                     32'(BEG_IND0 + 513), 32'(BEG_IND1 - 1), 32'(BEG_IND1),
                     32'(BEG_IND1 + 3 * 512 + 77), 32'(BEG_DIND - 1), 32'(BEG_DIND),
                     32'(BEG_DIND + 5 * PER_IND + 7 * 512 + 9),
                     32'(BEG_DIND + PER_IND), 32'(END_DIND - 1), 32'(END_DIND),
                     32'(END_DIND + 1), 32'h8000_0000, 32'hFFFF_FFFF,
                     32'h5555_5555, 32'hAAAA_AAAA};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k])
            send_word(directed[k]);
        repeat (RANDOM_WORDS)
            send_word(random_block_index());
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("file_block_to_node_path_core_test: clean");
        else
            $display("file_block_to_node_path_core_test: errors");
        $finish;
    end

    initial begin
        #2ms;
        $display("file_block_to_node_path_core_test: errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/fbnp_pkg.sv
hdl/file_block_to_node_path_core.sv
tb/node_path_checker.sv
tb/file_block_to_node_path_core_test.sv
